// ===== hw/rtl/stable_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// stable_priority_queue_defines.svh
// Assertion macros shared by the priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and defaults for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_DEPTH = 16;
    localparam int PRIO_W    = 8;
    localparam int TAG_W     = 16;
    localparam int DIST_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // one stored record
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        logic              kind;
        logic [DIST_W-1:0] distance;
    } rec_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
        rec_t rec;
    } cell_ctl_t;

    // what a cell hands to its neighbors
    typedef struct packed {
        logic keep;
        rec_t rec;
    } cell_link_t;

endpackage

// ===== hw/rtl/spq_req_if.sv =====
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: operation code and record to insert.
// ----------------------------------------------------------------------------
interface spq_req_if
    import spq_pkg::*;
();

    logic              valid;
    logic              ready;
    logic              func;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic              kind;
    logic [DIST_W-1:0] dist_req;

    modport source (
        output valid, func, prio, tag, kind, dist_req,
        input  ready
    );

    modport sink (
        input  valid, func, prio, tag, kind, dist_req,
        output ready
    );

endinterface

// ===== hw/rtl/spq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: status, popped record and occupancy.
// ----------------------------------------------------------------------------
interface spq_rsp_if
    import spq_pkg::*;
();

    logic                valid;
    logic                ready;
    logic                popped;
    logic [STATUS_W-1:0] status;
    logic [PRIO_W-1:0]   out_prio;
    logic [TAG_W-1:0]    out_tag;
    logic                out_kind;
    logic [DIST_W-1:0]   out_dist;
    logic [OCC_W-1:0]    occupancy;

    modport source (
        output valid, popped, status, out_prio, out_tag, out_kind, out_dist, occupancy,
        input  ready
    );

    modport sink (
        input  valid, popped, status, out_prio, out_tag, out_kind, out_dist, occupancy,
        output ready
    );

endinterface

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue. Decides locally whether to hold its record,
// take the new one, or take a neighbor's record.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [CNT_W-1:0] fill,
    input  cell_link_t       prev_link,
    input  rec_t             next_rec,
    output cell_link_t       link
);

    rec_t rec_reg;
    rec_t rec_next;
    logic occ;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    // slot holds a live record when it lies below the fill count
    assign occ = (IDX_C < fill);

    // record stays put on insert when it ranks equal or higher
    assign link.keep = occ && (rec_reg.prio >= ctl.rec.prio);
    assign link.rec  = rec_reg;

    // next content
    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.ins)
        begin
            if (!link.keep)
            begin
                rec_next = prev_link.keep ? ctl.rec : prev_link.rec;
            end
        end
        else if (ctl.pop)
        begin
            rec_next = next_rec;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

// ===== hw/rtl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded sorted priority queue built as a row of shifting cells. Inserts
// land behind all records of equal or higher priority; pops take the head.
//
//   channel | dir | payload
//   --------+-----+---------------------------------------------------------
//   req     | in  | func, prio, tag, kind, dist_req
//   rsp     | out | popped, status, out_prio, out_tag, out_kind, out_dist,
//           |     | occupancy
//
// Every cell compares against the new priority in parallel and the whole
// row shifts in the same edge. The result is registered at the transfer
// and held in an output register.
// req.ready is high while the output register is empty or being drained.
// Reset (rst_n low, async) empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef struct packed {
        logic                popped;
        logic [STATUS_W-1:0] status;
        rec_t                rec;
        logic [OCC_W-1:0]    occupancy;
    } result_t;

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             valid_reg;
    logic             valid_next;
    result_t          res_reg;
    result_t          res_next;

    logic             xfer;
    logic             full;
    logic             empty;
    cell_ctl_t        ctl;
    cell_link_t       lnk [DEPTH];
    logic [CNT_W+OCC_W-1:0] fill_ext;

    // handshake
    assign req.ready = !valid_reg || rsp.ready;
    assign xfer      = req.valid && req.ready;

    assign full  = (fill_reg == DEPTH_C);
    assign empty = (fill_reg == '0);

    // operation broadcast to the row
    always_comb
    begin
        ctl.ins          = xfer && (req.func == FUNC_INSERT) && !full;
        ctl.pop          = xfer && (req.func == FUNC_POP) && !empty;
        ctl.rec.prio     = req.prio;
        ctl.rec.tag      = req.tag;
        ctl.rec.kind     = req.kind;
        ctl.rec.distance = req.dist_req;
    end

    // cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_link_t prev_l;
        rec_t       next_r;

        if (i == 0)
        begin : g_head
            assign prev_l.keep = 1'b1;
            assign prev_l.rec  = ctl.rec;
        end
        else
        begin : g_body
            assign prev_l = lnk[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_r = lnk[i].rec;
        end
        else
        begin : g_inner
            assign next_r = lnk[i+1].rec;
        end

        spq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .fill      (fill_reg),
            .prev_link (prev_l),
            .next_rec  (next_r),
            .link      (lnk[i])
        );
    end

    // fill count update
    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.ins)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    assign fill_ext = {{OCC_W{1'b0}}, fill_next};

    // result formation
    always_comb
    begin
        res_next           = res_reg;
        valid_next         = valid_reg;
        if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
        if (xfer)
        begin
            valid_next         = 1'b1;
            res_next.popped    = ctl.pop;
            res_next.status    = ST_OK;
            res_next.rec       = '0;
            res_next.occupancy = fill_ext[OCC_W-1:0];
            if (req.func == FUNC_POP)
            begin
                if (empty)
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    res_next.rec = lnk[0].rec;
                end
            end
            else if (full)
            begin
                res_next.status = ST_FULL;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // response port
    assign rsp.valid     = valid_reg;
    assign rsp.popped    = res_reg.popped;
    assign rsp.status    = res_reg.status;
    assign rsp.out_prio  = res_reg.rec.prio;
    assign rsp.out_tag   = res_reg.rec.tag;
    assign rsp.out_kind  = res_reg.rec.kind;
    assign rsp.out_dist  = res_reg.rec.distance;
    assign rsp.occupancy = res_reg.occupancy;

    // checks
    `SPQ_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= DEPTH_C, "fill count above depth")
    `SPQ_ASSERT_IMP(a_head_order, fill_reg >= CNT_W'(2), lnk[0].rec.prio >= lnk[1].rec.prio, "head out of order")
    `SPQ_ASSERT_NXT(a_pop_count, ctl.pop, fill_reg == $past(fill_reg) - 1'b1, "pop did not drop fill")
    `SPQ_ASSERT_NXT(a_full_refuse, xfer && full && (req.func == FUNC_INSERT), (fill_reg == DEPTH_C) && (res_reg.status == ST_FULL), "full insert not refused")
    `SPQ_ASSERT_IMP(a_err_no_pop, valid_reg && (res_reg.status != ST_OK), !res_reg.popped, "record with error status")

endmodule

// ===== verif/stable_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// Self-checking bench for the stable priority queue. A small scoreboard keeps
// a sorted copy of the queue, works out the result of every request transfer
// and checks each response transfer in order. A short directed list comes
// first. Random runs follow, in stretches that mostly fill, mostly drain
// or mix the queue, under three sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
    import spq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    // one expected or observed response
    typedef struct packed {
        logic                popped;
        logic [STATUS_W-1:0] status;
        rec_t                rec;
        logic [OCC_W-1:0]    occupancy;
    } rsp_item_t;

    // sorted shadow of the queue plus the responses still owed
    class queue_scoreboard;
        rec_t      ranked[$];
        rsp_item_t due_results[$];
        int        errors;
        int        results_seen;
        int        inserts;
        int        full_refusals;
        int        pops;
        int        empty_pops;
        int        peak_fill;

        function int pending();
            return due_results.size();
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // new record goes behind every stored one of equal or higher priority
        function void note_request(input logic func, input rec_t r);
            rsp_item_t want;
            int        pos;
            want = '0;
            if (func == FUNC_INSERT) begin
                if (ranked.size() >= SPQ_DEPTH) begin
                    want.status = ST_FULL;
                    full_refusals++;
                end
                else begin
                    pos = 0;
                    while (pos < ranked.size() && ranked[pos].prio >= r.prio)
                        pos++;
                    ranked.insert(pos, r);
                    want.status = ST_OK;
                    inserts++;
                end
            end
            else begin
                if (ranked.size() == 0) begin
                    want.status = ST_EMPTY;
                    empty_pops++;
                end
                else begin
                    want.rec    = ranked.pop_front();
                    want.popped = 1'b1;
                    want.status = ST_OK;
                    pops++;
                end
            end
            want.occupancy = OCC_W'(ranked.size());
            if (ranked.size() > peak_fill)
                peak_fill = ranked.size();
            due_results.push_back(want);
        endfunction

        task field(input string name, input logic [31:0] got, input logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d field %s: got %0h, expected %0h",
                                 results_seen, name, got, want));
        endtask

        task check_result(input rsp_item_t got);
            rsp_item_t want;
            results_seen++;
            if (due_results.size() == 0) begin
                report($sformatf("result %0d arrived with no request outstanding",
                                 results_seen));
            end
            else begin
                want = due_results.pop_front();
                field("popped", 32'(got.popped), 32'(want.popped));
                field("status", 32'(got.status), 32'(want.status));
                field("out_prio", 32'(got.rec.prio), 32'(want.rec.prio));
                field("out_tag", 32'(got.rec.tag), 32'(want.rec.tag));
                field("out_kind", 32'(got.rec.kind), 32'(want.rec.kind));
                field("out_dist", 32'(got.rec.distance), 32'(want.rec.distance));
                field("occupancy", 32'(got.occupancy), 32'(want.occupancy));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    queue_scoreboard sb;
    int send_gap_pct;
    int recv_stall_pct;

    stable_priority_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic rec_t make_rec(input logic [PRIO_W-1:0] prio,
                                      input logic [TAG_W-1:0] tag,
                                      input logic kind,
                                      input logic [DIST_W-1:0] distance);
        rec_t r;
        r.prio     = prio;
        r.tag      = tag;
        r.kind     = kind;
        r.distance = distance;
        return r;
    endfunction

    // priorities lean toward ties and the extremes
    function automatic rec_t random_record();
        rec_t r;
        case ($urandom_range(0, 3))
            0: r.prio = PRIO_W'($urandom_range(0, 255));
            1: r.prio = PRIO_W'($urandom_range(0, 3));
            2: r.prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: r.prio = PRIO_W'($urandom_range(120, 135));
        endcase
        r.tag      = TAG_W'($urandom);
        r.kind     = 1'($urandom);
        r.distance = DIST_W'($urandom);
        return r;
    endfunction

    // one request transfer, with random idle cycles ahead of it
    task automatic send_op(input logic func, input rec_t r);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= func;
        req_ch.prio     <= r.prio;
        req_ch.tag      <= r.tag;
        req_ch.kind     <= r.kind;
        req_ch.dist_req <= r.distance;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(func, r);
    endtask

    // hold off the sender until every owed response is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // runs that mostly insert, mostly pop, or mix, so full and empty recur
    task automatic run_random(input int count);
        int   run_left;
        int   insert_pct;
        logic func;
        run_left   = 0;
        insert_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            run_left--;
            func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_POP;
            send_op(func, random_record());
            if (i != count - 1 && $urandom_range(0, 199) == 0)
                drain();
        end
    endtask

    // response side: check each transfer, then pick ready for the next cycle
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_result({rsp_ch.popped, rsp_ch.status, rsp_ch.out_prio,
                                 rsp_ch.out_tag, rsp_ch.out_kind, rsp_ch.out_dist,
                                 rsp_ch.occupancy});
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog: too many cycles with no transfer on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("stable_priority_queue regression: fail");
        $finish;
    end

    // main sequence
    initial
    begin
        sb              = new();
        send_gap_pct    = 6;
        recv_stall_pct  = 80;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= FUNC_INSERT;
        req_ch.prio     <= '0;
        req_ch.tag      <= '0;
        req_ch.kind     <= 1'b0;
        req_ch.dist_req <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, field extremes, ties at both ends and mid range
        send_op(FUNC_POP, make_rec(8'h00, 16'h0000, 1'b0, 16'h0000));
        send_op(FUNC_INSERT, make_rec(8'h00, 16'h0000, 1'b0, 16'h0000));
        send_op(FUNC_INSERT, make_rec(8'hFF, 16'hFFFF, 1'b1, 16'hFFFF));
        send_op(FUNC_INSERT, make_rec(8'h80, 16'h1111, 1'b0, 16'h0001));
        send_op(FUNC_INSERT, make_rec(8'h80, 16'h2222, 1'b1, 16'h0002));
        send_op(FUNC_INSERT, make_rec(8'hFF, 16'h3333, 1'b0, 16'h8000));
        send_op(FUNC_INSERT, make_rec(8'h00, 16'h4444, 1'b1, 16'h7FFF));
        send_op(FUNC_INSERT, make_rec(8'h81, 16'h5555, 1'b0, 16'hAAAA));
        repeat (7)
            send_op(FUNC_POP, make_rec(8'hFF, 16'hFFFF, 1'b1, 16'hFFFF));
        // pop on empty with junk in the ignored fields
        send_op(FUNC_POP, make_rec(8'hA5, 16'h5AA5, 1'b1, 16'hC33C));

        // random phases under the three stall patterns
        run_random(480);
        drain();
        send_gap_pct   = 80;
        recv_stall_pct = 6;
        run_random(485);
        drain();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_random(485);
        drain();
        repeat (4) @(posedge clk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("covered %0d inserts, %0d refused on full, %0d pops, %0d pops on empty",
                 sb.inserts, sb.full_refusals, sb.pops, sb.empty_pops);
        $display("peak fill %0d of %0d, %0d results checked, %0d mismatches",
                 sb.peak_fill, SPQ_DEPTH, sb.results_seen, sb.errors);
        if (sb.errors == 0)
            $display("stable_priority_queue regression: pass");
        else
            $display("stable_priority_queue regression: fail");
        $finish;
    end

endmodule
